/* rtl/log_message_ring_buffer_unit_defines.svh */
// assertion macros for the log message ring buffer unit
// no dependencies; included by the modules that carry assertions
`ifndef LOG_MESSAGE_RING_BUFFER_UNIT_DEFINES_SVH
`define LOG_MESSAGE_RING_BUFFER_UNIT_DEFINES_SVH

`ifndef SYNTHESIS

// clocked check, switched off while reset is high
`define LMRB_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked check that also holds across reset
`define LMRB_ASSERT_NORST(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`else

`define LMRB_ASSERT(label, clk, rst, prop, msg)
`define LMRB_ASSERT_NORST(label, clk, prop, msg)

`endif

`endif

/* rtl/lmrb_pkg.sv */
// shared types and constants of the log message ring buffer unit
// used by lmrb_ctrl, lmrb_datapath and the top level
package lmrb_pkg;

   // store geometry
   localparam int ADDR_W = 8;
   localparam int DEPTH  = 1 << ADDR_W;
   localparam int SIZE_W = ADDR_W + 1;

   localparam logic [7:0] SPACE_BYTE = 8'h20;
   localparam logic [7:0] NUL_BYTE   = 8'h00;

   // operation codes
   localparam logic [2:0] OP_PUT     = 3'd0;
   localparam logic [2:0] OP_GET     = 3'd1;
   localparam logic [2:0] OP_ADVANCE = 3'd2;
   localparam logic [2:0] OP_READ    = 3'd3;
   localparam logic [2:0] OP_CLEAR   = 3'd4;
   localparam logic [2:0] OP_RELEASE = 3'd5;

   // status codes
   localparam logic [2:0] ST_OK       = 3'd0;
   localparam logic [2:0] ST_NO_INIT  = 3'd1;
   localparam logic [2:0] ST_EMPTY    = 3'd2;
   localparam logic [2:0] ST_FULL     = 3'd3;
   localparam logic [2:0] ST_TRUNC    = 3'd4;
   localparam logic [2:0] ST_COMPLETE = 3'd5;
   localparam logic [2:0] ST_SPLIT    = 3'd6;

   // message flag bits
   localparam int FLAG_TRUNC_BIT  = 0;
   localparam int FLAG_REJECT_BIT = 1;

   // datapath step requested by the controller
   typedef enum logic [3:0] {
      DP_IDLE,
      DP_PUT,
      DP_GET_START,
      DP_GET_READ,
      DP_GET_CHECK,
      DP_ADV_START,
      DP_ADV_FILL,
      DP_READ_ISSUE,
      DP_READ_TAKE,
      DP_CLEAR_START,
      DP_CLEAR_FILL,
      DP_RELEASE,
      DP_RESULT_OK,
      DP_RESULT_NO_INIT,
      DP_RESULT_EMPTY
   } dp_op_type;

   typedef struct packed {
      logic      req_load;
      logic      rsp_load;
      dp_op_type op;
   } dp_cmd_type;

   typedef struct packed {
      logic [2:0] op;
      logic       ready;
      logic       used_zero;
      logic       fetched_zero;
      logic       scan_hit;
      logic       scan_end;
      logic       fill_last;
      logic       sweep_last;
      logic       rsp_free;
   } dp_status_type;

endpackage

/* rtl/lmrb_ctrl.sv */
// controller state machine of the log message ring buffer unit
// depends on lmrb_pkg and the assertion macro header
`include "log_message_ring_buffer_unit_defines.svh"

module lmrb_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  lmrb_pkg::dp_status_type status,
   output lmrb_pkg::dp_cmd_type    cmd
);
   import lmrb_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE,
      S_EXEC,
      S_GET_RD,
      S_GET_CHK,
      S_ADV_FILL,
      S_RB_WAIT,
      S_CLR_FILL,
      S_DONE
   } state_type;

   state_type state_ff;
   state_type state_in;

   // a new transaction is taken when idle or while the last result is pushed out
   assign req_ready = (state_ff == S_IDLE) || ((state_ff == S_DONE) && status.rsp_free);

   // next state and datapath commands
   always_comb begin
      state_in     = state_ff;
      cmd.req_load = 1'b0;
      cmd.rsp_load = 1'b0;
      cmd.op       = DP_IDLE;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.req_load = 1'b1;
               state_in     = S_EXEC;
            end
         end
         S_EXEC: begin
            state_in = S_DONE;
            unique case (status.op)
               OP_PUT: begin
                  cmd.op = DP_PUT;
               end
               OP_GET: begin
                  if (!status.ready) begin
                     cmd.op = DP_RESULT_NO_INIT;
                  end else if (status.used_zero) begin
                     cmd.op = DP_RESULT_EMPTY;
                  end else begin
                     cmd.op   = DP_GET_START;
                     state_in = S_GET_RD;
                  end
               end
               OP_ADVANCE: begin
                  if (!status.ready) begin
                     cmd.op = DP_RESULT_NO_INIT;
                  end else if (status.fetched_zero) begin
                     cmd.op = DP_RESULT_OK;
                  end else begin
                     cmd.op   = DP_ADV_START;
                     state_in = S_ADV_FILL;
                  end
               end
               OP_READ: begin
                  if (!status.ready) begin
                     cmd.op = DP_RESULT_NO_INIT;
                  end else begin
                     cmd.op   = DP_READ_ISSUE;
                     state_in = S_RB_WAIT;
                  end
               end
               OP_CLEAR: begin
                  cmd.op   = DP_CLEAR_START;
                  state_in = S_CLR_FILL;
               end
               OP_RELEASE: begin
                  cmd.op = DP_RELEASE;
               end
               default: begin
                  cmd.op = DP_RESULT_OK;
               end
            endcase
         end
         S_GET_RD: begin
            cmd.op   = DP_GET_READ;
            state_in = S_GET_CHK;
         end
         S_GET_CHK: begin
            cmd.op = DP_GET_CHECK;
            if (status.scan_hit || status.scan_end) begin
               state_in = S_DONE;
            end else begin
               state_in = S_GET_RD;
            end
         end
         S_ADV_FILL: begin
            cmd.op = DP_ADV_FILL;
            if (status.fill_last) begin
               state_in = S_DONE;
            end
         end
         S_RB_WAIT: begin
            cmd.op   = DP_READ_TAKE;
            state_in = S_DONE;
         end
         S_CLR_FILL: begin
            cmd.op = DP_CLEAR_FILL;
            if (status.sweep_last) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (status.rsp_free) begin
               cmd.rsp_load = 1'b1;
               if (req_valid) begin
                  cmd.req_load = 1'b1;
                  state_in     = S_EXEC;
               end else begin
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // checks
   `LMRB_ASSERT(a_accept_starts_exec, clock, reset, (req_valid && req_ready) |=> (state_ff == S_EXEC), "accepted transaction did not enter execute")
   `LMRB_ASSERT(a_check_follows_read, clock, reset, (state_ff == S_GET_CHK) |-> ($past(state_ff) == S_GET_RD), "scan check without a preceding store read")
   `LMRB_ASSERT(a_push_needs_room, clock, reset, cmd.rsp_load |-> status.rsp_free, "result pushed while output register busy")

endmodule

/* rtl/lmrb_datapath.sv */
// datapath of the log message ring buffer unit: store, pointers, message state
// and output register; depends on lmrb_pkg and the assertion macro header
`include "log_message_ring_buffer_unit_defines.svh"

module lmrb_datapath (
   input  logic                   clock,
   input  logic                   reset,
   input  logic [2:0]             req_operation,
   input  logic [7:0]             req_char_in,
   input  logic [7:0]             req_read_index,
   input  logic                   csr_write_enable,
   input  logic [8:0]             csr_write_data,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [2:0]             rsp_status,
   output logic [7:0]             rsp_start_index,
   output logic [8:0]             rsp_length,
   output logic [7:0]             rsp_char_out,
   input  lmrb_pkg::dp_cmd_type    cmd,
   output lmrb_pkg::dp_status_type status
);
   import lmrb_pkg::*;

   localparam logic [SIZE_W-1:0] DEPTH_SIZE = SIZE_W'(DEPTH);
   localparam logic [SIZE_W-1:0] ONE_SIZE   = SIZE_W'(1);

   // store
   logic [7:0]        mem [DEPTH];
   logic [7:0]        rd_data_ff;
   logic              mem_we;
   logic [ADDR_W-1:0] mem_waddr;
   logic [7:0]        mem_wdata;
   logic [ADDR_W-1:0] mem_raddr;

   // latched transaction
   logic [2:0]        op_ff, op_in;
   logic [7:0]        char_ff, char_in;
   logic [7:0]        idx_ff, idx_in;

   // configuration and ring state
   logic [SIZE_W-1:0] buffer_size_ff, buffer_size_in;
   logic [SIZE_W-1:0] ring_size_ff, ring_size_in;
   logic [ADDR_W-1:0] write_pos_ff, write_pos_in;
   logic [ADDR_W-1:0] read_pos_ff, read_pos_in;
   logic [SIZE_W-1:0] used_ff, used_in;
   logic [SIZE_W-1:0] fetched_ff, fetched_in;
   logic              ready_ff, ready_in;
   logic              in_msg_ff, in_msg_in;
   logic [SIZE_W-1:0] room_ff, room_in;
   logic [1:0]        flags_ff, flags_in;

   // walking pointer for scan and fill
   logic [ADDR_W-1:0] walk_ff, walk_in;
   logic [SIZE_W-1:0] fill_cnt_ff, fill_cnt_in;

   // pending result
   logic [2:0]        res_status_ff, res_status_in;
   logic [7:0]        res_start_ff, res_start_in;
   logic [8:0]        res_len_ff, res_len_in;
   logic [7:0]        res_char_ff, res_char_in;

   // output register
   logic              rsp_valid_ff, rsp_valid_in;
   logic [2:0]        rsp_status_ff, rsp_status_in;
   logic [7:0]        rsp_start_ff, rsp_start_in;
   logic [8:0]        rsp_len_ff, rsp_len_in;
   logic [7:0]        rsp_char_ff, rsp_char_in;

   // derived values
   logic [SIZE_W-1:0] clamp_size;
   logic [ADDR_W-1:0] walk_next;
   logic [ADDR_W-1:0] write_next;
   logic [SIZE_W-1:0] scan_len;
   logic [SIZE_W-1:0] read_pos_ext;
   logic [SIZE_W:0]   fetch_end;

   // put decision
   logic [2:0]        put_status;
   logic              put_store;
   logic              put_in_msg;
   logic [SIZE_W-1:0] put_room;
   logic [1:0]        put_flags;

   assign read_pos_ext = {1'b0, read_pos_ff};
   assign fetch_end    = {1'b0, read_pos_ext} + {1'b0, fetched_ff};

   // ring size from the register, zero acting as one, clamped to the depth
   always_comb begin
      if (buffer_size_ff == '0) begin
         clamp_size = ONE_SIZE;
      end else if (buffer_size_ff > DEPTH_SIZE) begin
         clamp_size = DEPTH_SIZE;
      end else begin
         clamp_size = buffer_size_ff;
      end
   end

   // pointer steps with wrap at the ring size
   assign walk_next  = (({1'b0, walk_ff} + ONE_SIZE) == ring_size_ff) ? '0 : walk_ff + 1'b1;
   assign write_next = (({1'b0, write_pos_ff} + ONE_SIZE) == ring_size_ff) ? '0
                                                                          : write_pos_ff + 1'b1;
   assign scan_len   = {1'b0, walk_ff} - read_pos_ext + ONE_SIZE;

   // put character: message start, rejection, truncation
   always_comb begin
      logic [SIZE_W-1:0] free_v;
      logic              reject_v;
      free_v     = ring_size_ff - used_ff;
      put_status = ST_OK;
      put_store  = 1'b0;
      put_in_msg = in_msg_ff;
      put_room   = room_ff;
      put_flags  = flags_ff;
      reject_v   = 1'b0;
      if (!ready_ff) begin
         put_status = ST_NO_INIT;
      end else begin
         if (!in_msg_ff) begin
            put_flags = '0;
            if (free_v == '0) begin
               // no room at message start: whole message dropped
               put_flags[FLAG_REJECT_BIT] = 1'b1;
               put_in_msg                 = (char_ff != NUL_BYTE);
               put_status                 = ST_FULL;
               reject_v                   = 1'b1;
            end else begin
               put_room   = free_v - ONE_SIZE;
               put_in_msg = 1'b1;
            end
         end
         if (!reject_v) begin
            if (put_flags[FLAG_REJECT_BIT]) begin
               put_status = ST_FULL;
               if (char_ff == NUL_BYTE) begin
                  put_in_msg = 1'b0;
                  put_flags  = '0;
               end
            end else if (char_ff == NUL_BYTE) begin
               put_store  = 1'b1;
               put_status = put_flags[FLAG_TRUNC_BIT] ? ST_TRUNC : ST_OK;
               put_in_msg = 1'b0;
               put_flags  = '0;
               put_room   = '0;
            end else begin
               if (put_room != '0) begin
                  put_store = 1'b1;
                  put_room  = put_room - ONE_SIZE;
               end else begin
                  put_flags[FLAG_TRUNC_BIT] = 1'b1;
               end
               put_status = put_flags[FLAG_TRUNC_BIT] ? ST_TRUNC : ST_OK;
            end
         end
      end
   end

   // next values of all registers
   always_comb begin
      op_in          = op_ff;
      char_in        = char_ff;
      idx_in         = idx_ff;
      buffer_size_in = buffer_size_ff;
      ring_size_in   = ring_size_ff;
      write_pos_in   = write_pos_ff;
      read_pos_in    = read_pos_ff;
      used_in        = used_ff;
      fetched_in     = fetched_ff;
      ready_in       = ready_ff;
      in_msg_in      = in_msg_ff;
      room_in        = room_ff;
      flags_in       = flags_ff;
      walk_in        = walk_ff;
      fill_cnt_in    = fill_cnt_ff;
      res_status_in  = res_status_ff;
      res_start_in   = res_start_ff;
      res_len_in     = res_len_ff;
      res_char_in    = res_char_ff;
      mem_we         = 1'b0;
      mem_waddr      = walk_ff;
      mem_wdata      = SPACE_BYTE;
      mem_raddr      = (cmd.op == DP_READ_ISSUE) ? idx_ff : walk_ff;

      // take a new transaction and reset its result fields
      if (cmd.req_load) begin
         op_in         = req_operation;
         char_in       = req_char_in;
         idx_in        = req_read_index;
         res_status_in = ST_OK;
         res_start_in  = '0;
         res_len_in    = '0;
         res_char_in   = '0;
      end

      unique case (cmd.op)
         DP_IDLE: begin
         end
         DP_PUT: begin
            res_status_in = put_status;
            in_msg_in     = put_in_msg;
            room_in       = put_room;
            flags_in      = put_flags;
            if (put_store) begin
               mem_we       = 1'b1;
               mem_waddr    = write_pos_ff;
               mem_wdata    = char_ff;
               write_pos_in = write_next;
               if (used_ff < ring_size_ff) begin
                  used_in = used_ff + ONE_SIZE;
               end
            end
         end
         DP_GET_START: begin
            walk_in      = read_pos_ff;
            res_start_in = read_pos_ff;
         end
         DP_GET_READ: begin
         end
         DP_GET_CHECK: begin
            // terminator found or physical end of the ring reached
            if (status.scan_hit || status.scan_end) begin
               res_len_in    = scan_len;
               fetched_in    = scan_len;
               res_status_in = status.scan_hit ? ST_COMPLETE : ST_SPLIT;
            end else begin
               walk_in = walk_ff + 1'b1;
            end
         end
         DP_ADV_START: begin
            walk_in     = read_pos_ff;
            fill_cnt_in = fetched_ff;
         end
         DP_ADV_FILL: begin
            mem_we      = 1'b1;
            walk_in     = walk_next;
            fill_cnt_in = fill_cnt_ff - ONE_SIZE;
            if (status.fill_last) begin
               read_pos_in = walk_next;
               used_in     = (fetched_ff > used_ff) ? '0 : used_ff - fetched_ff;
               fetched_in  = '0;
            end
         end
         DP_READ_ISSUE: begin
         end
         DP_READ_TAKE: begin
            res_char_in = rd_data_ff;
         end
         DP_CLEAR_START: begin
            ring_size_in = clamp_size;
            write_pos_in = '0;
            read_pos_in  = '0;
            used_in      = '0;
            fetched_in   = '0;
            in_msg_in    = 1'b0;
            room_in      = '0;
            flags_in     = '0;
            ready_in     = 1'b1;
            walk_in      = '0;
         end
         DP_CLEAR_FILL: begin
            mem_we  = 1'b1;
            walk_in = walk_ff + 1'b1;
         end
         DP_RELEASE: begin
            ready_in = 1'b0;
         end
         DP_RESULT_OK: begin
            res_status_in = ST_OK;
         end
         DP_RESULT_NO_INIT: begin
            res_status_in = ST_NO_INIT;
         end
         DP_RESULT_EMPTY: begin
            res_status_in = ST_EMPTY;
         end
         default: begin
         end
      endcase

      // configuration write
      if (csr_write_enable) begin
         buffer_size_in = csr_write_data;
      end
   end

   // output register
   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_start_in  = rsp_start_ff;
      rsp_len_in    = rsp_len_ff;
      rsp_char_in   = rsp_char_ff;
      if (cmd.rsp_load) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = res_status_ff;
         rsp_start_in  = res_start_ff;
         rsp_len_in    = res_len_ff;
         rsp_char_in   = res_char_ff;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // store: one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= mem[mem_raddr];
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         buffer_size_ff <= DEPTH_SIZE;
         ring_size_ff   <= DEPTH_SIZE;
         write_pos_ff   <= '0;
         read_pos_ff    <= '0;
         used_ff        <= '0;
         fetched_ff     <= '0;
         ready_ff       <= 1'b0;
         in_msg_ff      <= 1'b0;
         room_ff        <= '0;
         flags_ff       <= '0;
         walk_ff        <= '0;
         fill_cnt_ff    <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         buffer_size_ff <= buffer_size_in;
         ring_size_ff   <= ring_size_in;
         write_pos_ff   <= write_pos_in;
         read_pos_ff    <= read_pos_in;
         used_ff        <= used_in;
         fetched_ff     <= fetched_in;
         ready_ff       <= ready_in;
         in_msg_ff      <= in_msg_in;
         room_ff        <= room_in;
         flags_ff       <= flags_in;
         walk_ff        <= walk_in;
         fill_cnt_ff    <= fill_cnt_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      char_ff       <= char_in;
      idx_ff        <= idx_in;
      res_status_ff <= res_status_in;
      res_start_ff  <= res_start_in;
      res_len_ff    <= res_len_in;
      res_char_ff   <= res_char_in;
      rsp_status_ff <= rsp_status_in;
      rsp_start_ff  <= rsp_start_in;
      rsp_len_ff    <= rsp_len_in;
      rsp_char_ff   <= rsp_char_in;
   end

   // status towards the controller
   assign status.op           = op_ff;
   assign status.ready        = ready_ff;
   assign status.used_zero    = (used_ff == '0);
   assign status.fetched_zero = (fetched_ff == '0);
   assign status.scan_hit     = (rd_data_ff == NUL_BYTE);
   assign status.scan_end     = (({1'b0, walk_ff} + ONE_SIZE) == ring_size_ff);
   assign status.fill_last    = (fill_cnt_ff == ONE_SIZE);
   assign status.sweep_last   = (walk_ff == '1);
   assign status.rsp_free     = !rsp_valid_ff || rsp_ready;

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_start_index = rsp_start_ff;
   assign rsp_length      = rsp_len_ff;
   assign rsp_char_out    = rsp_char_ff;

   // checks
   `LMRB_ASSERT(a_used_within_ring, clock, reset, used_ff <= ring_size_ff, "used count exceeds ring size")
   `LMRB_ASSERT(a_read_pos_within_ring, clock, reset, read_pos_ext < ring_size_ff, "read position outside ring")
   `LMRB_ASSERT(a_fetch_within_ring, clock, reset, fetch_end <= {1'b0, ring_size_ff}, "fetched span runs past ring end")
   `LMRB_ASSERT_NORST(a_reset_empties_output, clock, reset |=> (!rsp_valid_ff && !ready_ff), "reset left output valid or store ready")

endmodule

/* rtl/log_message_ring_buffer_unit.sv */
// top level of the log message ring buffer unit
// instantiates lmrb_ctrl and lmrb_datapath; depends on lmrb_pkg
//
//   channel   direction  handshake              payload
//   req_      in         req_valid / req_ready  operation, char_in, read_index
//   rsp_      out        rsp_valid / rsp_ready  status, start_index, length, char_out
//   csr_      in         csr_write_enable       buffer_size (csr_write_data)
//
// put, release and the not-initialised, empty and plain cases go from execute to done;
// read byte issues a registered store read and then takes the data; get does a registered
// store read, then a check, per byte scanned; advance writes a space over each fetched
// byte; clear writes spaces over all 256 store bytes; reset is synchronous and clears
// control state only; store bytes are undefined until a clear; a transaction is taken
// while a result waits, and work stalls at its end until the output register frees up
module log_message_ring_buffer_unit (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [2:0] req_operation,
   input  logic [7:0] req_char_in,
   input  logic [7:0] req_read_index,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [2:0] rsp_status,
   output logic [7:0] rsp_start_index,
   output logic [8:0] rsp_length,
   output logic [7:0] rsp_char_out,
   input  logic       csr_write_enable,
   input  logic [8:0] csr_write_data
);
   import lmrb_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type status;

   // sequencer
   lmrb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // store and registers
   lmrb_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .req_operation    (req_operation),
      .req_char_in      (req_char_in),
      .req_read_index   (req_read_index),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_status       (rsp_status),
      .rsp_start_index  (rsp_start_index),
      .rsp_length       (rsp_length),
      .rsp_char_out     (rsp_char_out),
      .cmd              (cmd),
      .status           (status)
   );

endmodule
